// ===== src/p1305_pkg.sv =====
package p1305_pkg;

    // limb layout of the 130-bit values
    localparam int LIMB_W      = 26;
    localparam int NUM_LIMBS   = 5;
    localparam int ACC_W       = LIMB_W * NUM_LIMBS;
    localparam int KEY_W       = 128;
    localparam int WORD_W      = 64;

    // multiplier operands: h limb plus message limb, and 5 * r limb
    localparam int HL_W        = LIMB_W + 1;
    localparam int CO_W        = LIMB_W + 3;
    localparam int PROD_W      = HL_W + CO_W;

    // column sums and carries
    localparam int D_W         = 60;
    localparam int CARRY_W     = D_W - LIMB_W;

    // sequencer counters
    localparam int CNT_W       = 3;
    localparam int PASS_W      = 2;
    localparam int NORM_PASSES = 3;
    localparam logic [CNT_W-1:0]  LAST_LIMB = CNT_W'(NUM_LIMBS - 1);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NORM_PASSES - 1);

endpackage

// ===== src/p1305_mulmod.sv =====
module p1305_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [p1305_pkg::ACC_W-1:0] acc,
    input  logic [p1305_pkg::ACC_W-1:0] msg,
    input  logic [p1305_pkg::KEY_W-1:0] r,
    output logic                       done,
    output logic [p1305_pkg::ACC_W-1:0] prod
);
    import p1305_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_NORM} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [CARRY_W-1:0]   carry_reg, carry_next;
    logic                 done_reg, done_next;
    logic [D_W-1:0]       d_reg [NUM_LIMBS];
    logic [D_W-1:0]       d_next [NUM_LIMBS];

    logic [ACC_W-1:0]     r_ext;
    logic [LIMB_W-1:0]    acc_sel, msg_sel, r_sel;
    logic [HL_W-1:0]      h_limb;
    logic [CO_W-1:0]      r_wide, r_five, coef;
    logic [CNT_W:0]       col_sum;
    logic                 col_wrap;
    logic [CNT_W-1:0]     col_idx, rd_idx;
    logic [PROD_W-1:0]    product;
    logic [D_W-1:0]       rd_val, norm_sum;
    logic [CARRY_W-1:0]   norm_carry;
    logic [CARRY_W+2:0]   fold;

    // operand selection for the shared multiplier
    assign r_ext   = {{(ACC_W-KEY_W){1'b0}}, r};
    assign acc_sel = acc[LIMB_W*i_reg +: LIMB_W];
    assign msg_sel = msg[LIMB_W*i_reg +: LIMB_W];
    assign r_sel   = r_ext[LIMB_W*j_reg +: LIMB_W];
    assign h_limb  = {1'b0, acc_sel} + {1'b0, msg_sel};
    assign r_wide  = {3'b000, r_sel};
    assign r_five  = (r_wide << 2) + r_wide;

    // column of this partial product, wrapping columns fold in as 5 * r
    assign col_sum  = {1'b0, i_reg} + {1'b0, j_reg};
    assign col_wrap = (col_sum >= (CNT_W+1)'(NUM_LIMBS));
    assign col_idx  = col_wrap ? CNT_W'(col_sum - (CNT_W+1)'(NUM_LIMBS)) : col_sum[CNT_W-1:0];
    assign coef     = col_wrap ? r_five : r_wide;
    assign product  = h_limb * coef;

    // one column read per cycle, by column in multiply and by limb in carry pass
    assign rd_idx     = (state_reg == S_NORM) ? i_reg : col_idx;
    assign rd_val     = d_reg[rd_idx];
    assign norm_sum   = rd_val + D_W'(carry_reg);
    assign norm_carry = norm_sum[D_W-1:LIMB_W];
    assign fold       = ({norm_carry, 2'b00}) + {2'b00, norm_carry};

    // sequencer: 25 multiply-accumulate steps, then 3 carry passes of 5 limbs
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pass_next  = pass_reg;
        carry_next = carry_reg;
        done_next  = 1'b0;
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            d_next[k] = d_reg[k];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    for (int k = 0; k < NUM_LIMBS; k++)
                    begin
                        d_next[k] = '0;
                    end
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                d_next[col_idx] = rd_val + D_W'(product);
                if (j_reg == LAST_LIMB)
                begin
                    j_next = '0;
                    if (i_reg == LAST_LIMB)
                    begin
                        i_next     = '0;
                        pass_next  = '0;
                        carry_next = '0;
                        state_next = S_NORM;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_NORM:
            begin
                d_next[i_reg] = D_W'(norm_sum[LIMB_W-1:0]);
                if (i_reg == LAST_LIMB)
                begin
                    // overflow above 2^130 comes back in as times 5
                    d_next[0]  = d_reg[0] + D_W'(fold);
                    carry_next = '0;
                    i_next     = '0;
                    if (pass_reg == LAST_PASS)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                    end
                end
                else
                begin
                    carry_next = norm_carry;
                    i_next     = i_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            pass_reg  <= '0;
            carry_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
            carry_reg <= carry_next;
            done_reg  <= done_next;
        end
    end

    // column sums
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            d_reg[k] <= d_next[k];
        end
    end

    // reduced product, 26 bits from each column
    always_comb
    begin
        for (int k = 0; k < NUM_LIMBS; k++)
        begin
            prod[LIMB_W*k +: LIMB_W] = d_reg[k][LIMB_W-1:0];
        end
    end

    assign done = done_reg;

`ifndef ASSERT_OFF
    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("mulmod done held longer than one cycle");

    // a new product only starts when the sequencer is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("mulmod started while busy");

    // after the carry passes columns 1 and 4 hold no carry
    a_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (d_reg[1][D_W-1:LIMB_W] == '0) && (d_reg[4][D_W-1:LIMB_W] == '0))
        else $error("mulmod columns not normalized at done");
`endif

endmodule

// ===== src/poly1305_mac.sv =====
// Poly1305 one-time authenticator.
// Configuration: write the clamped-inside r key (key_r_low/high), the pad s
// (key_s_low/high) and, for verify mode, expected_tag_low/high through
// cfg_wr_en / cfg_index / cfg_data while no message is in flight.
// Input channel (in_valid/in_ready): one transaction per 16-byte message
// block, with byte_count valid bytes and last_block on the final one; an
// empty message is a single last transaction with byte_count zero.
// Output channel (out_valid/out_ready): one transaction per message, carrying
// tag_low/tag_high and tag_matches against the expected tag.
// Sequencing: a block with data drops in_ready after acceptance until its
// product is back, so no new block is taken while one is absorbed: the
// multiply-accumulate steps on the single 27x29 multiplier, the carry passes
// and a handoff back to idle. A last block then passes through final
// reduction, pad add and output load before its tag appears, as does an
// empty last block, which skips the multiply.
// A stalled output holds its tag; the next message may start meanwhile, and
// its tag waits in the final stage until the output register frees.
// Reset clears keys, expected tag, accumulator and output valid; no sweep.
module poly1305_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [p1305_pkg::WORD_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [p1305_pkg::WORD_W-1:0]  block_low,
    input  logic [p1305_pkg::WORD_W-1:0]  block_high,
    input  logic [4:0]                    byte_count,
    input  logic                          last_block,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [p1305_pkg::WORD_W-1:0]  tag_low,
    output logic [p1305_pkg::WORD_W-1:0]  tag_high,
    output logic                          tag_matches
);
    import p1305_pkg::*;

    typedef enum logic [2:0] {
        REG_KEY_R_LOW,
        REG_KEY_R_HIGH,
        REG_KEY_S_LOW,
        REG_KEY_S_HIGH,
        REG_EXP_TAG_LOW,
        REG_EXP_TAG_HIGH
    } cfg_reg_t;

    typedef enum logic [2:0] {ST_IDLE, ST_MULT, ST_RED, ST_ADD, ST_OUT} state_t;

    localparam logic [WORD_W-1:0] R_LO_MASK = 64'h0ffffffc0fffffff;
    localparam logic [WORD_W-1:0] R_HI_MASK = 64'h0ffffffc0ffffffc;
    localparam logic [4:0]        FULL_BLK  = 5'd16;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   r_lo_reg, r_lo_next, r_hi_reg, r_hi_next;
    logic [WORD_W-1:0]   s_lo_reg, s_lo_next, s_hi_reg, s_hi_next;
    logic [WORD_W-1:0]   exp_lo_reg, exp_lo_next, exp_hi_reg, exp_hi_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    msg_reg, msg_next;
    logic                last_reg, last_next;
    logic [KEY_W-1:0]    sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    tag_reg, tag_next;
    logic                match_reg, match_next;

    logic                in_fire;
    logic [4:0]          n_eff;
    logic [6:0]          pad_shift;
    logic [KEY_W-1:0]    blk_full, pad_bit, blk_mask;
    logic [ACC_W-1:0]    m_pad;
    logic [KEY_W-1:0]    r_clamped;
    logic [ACC_W:0]      g_sum;
    logic                mr_start, mr_done;
    logic [ACC_W-1:0]    mr_prod;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // pad the block: bytes past the count dropped, a one bit just above them
    assign n_eff     = (byte_count > FULL_BLK) ? FULL_BLK : byte_count;
    assign pad_shift = {n_eff[3:0], 3'b000};
    assign blk_full  = {block_high, block_low};
    assign pad_bit   = {{(KEY_W-1){1'b0}}, 1'b1} << pad_shift;
    assign blk_mask  = pad_bit - 1'b1;
    assign m_pad     = n_eff[4] ? {2'b01, blk_full}
                                : {2'b00, (blk_full & blk_mask) | pad_bit};

    assign r_clamped = {r_hi_reg & R_HI_MASK, r_lo_reg & R_LO_MASK};
    assign mr_start  = in_fire && (n_eff != '0);

    // final reduction candidate h + 5, taken when it passes 2^130
    assign g_sum = {1'b0, acc_reg} + (ACC_W+1)'(5);

    p1305_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mr_start),
        .acc   (acc_reg),
        .msg   (msg_reg),
        .r     (r_clamped),
        .done  (mr_done),
        .prod  (mr_prod)
    );

    // sequencer and register file
    always_comb
    begin
        state_next     = state_reg;
        r_lo_next      = r_lo_reg;
        r_hi_next      = r_hi_reg;
        s_lo_next      = s_lo_reg;
        s_hi_next      = s_hi_reg;
        exp_lo_next    = exp_lo_reg;
        exp_hi_next    = exp_hi_reg;
        acc_next       = acc_reg;
        msg_next       = msg_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        tag_next       = tag_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KEY_R_LOW:    r_lo_next   = cfg_data;
                REG_KEY_R_HIGH:   r_hi_next   = cfg_data;
                REG_KEY_S_LOW:    s_lo_next   = cfg_data;
                REG_KEY_S_HIGH:   s_hi_next   = cfg_data;
                REG_EXP_TAG_LOW:  exp_lo_next = cfg_data;
                REG_EXP_TAG_HIGH: exp_hi_next = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    msg_next  = m_pad;
                    last_next = last_block;
                    if (n_eff != '0)
                    begin
                        state_next = ST_MULT;
                    end
                    else if (last_block)
                    begin
                        state_next = ST_RED;
                    end
                end
            end
            ST_MULT:
            begin
                if (mr_done)
                begin
                    acc_next   = mr_prod;
                    state_next = last_reg ? ST_RED : ST_IDLE;
                end
            end
            ST_RED:
            begin
                if (g_sum[ACC_W])
                begin
                    acc_next = g_sum[ACC_W-1:0];
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                sum_next   = acc_reg[KEY_W-1:0] + {s_hi_reg, s_lo_reg};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while an earlier tag is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    tag_next       = sum_reg;
                    match_next     = (sum_reg == {exp_hi_reg, exp_lo_reg});
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_lo_reg      <= '0;
            r_hi_reg      <= '0;
            s_lo_reg      <= '0;
            s_hi_reg      <= '0;
            exp_lo_reg    <= '0;
            exp_hi_reg    <= '0;
            acc_reg       <= '0;
            msg_reg       <= '0;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            tag_reg       <= '0;
            match_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_lo_reg      <= r_lo_next;
            r_hi_reg      <= r_hi_next;
            s_lo_reg      <= s_lo_next;
            s_hi_reg      <= s_hi_next;
            exp_lo_reg    <= exp_lo_next;
            exp_hi_reg    <= exp_hi_next;
            acc_reg       <= acc_next;
            msg_reg       <= msg_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            tag_reg       <= tag_next;
            match_reg     <= match_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tag_low     = tag_reg[WORD_W-1:0];
    assign tag_high    = tag_reg[KEY_W-1:WORD_W];
    assign tag_matches = match_reg;

`ifndef ASSERT_OFF
    // the multiplier only reports back while a block is being absorbed
    a_done_in_mult: assert property (@(posedge clk) disable iff (!rst_n)
        mr_done |-> (state_reg == ST_MULT))
        else $error("multiply finished outside the multiply state");

    // a new tag transaction only comes from the output stage
    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("tag raised without passing the output stage");

    // a finished tag waits while the previous one is still stalled
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && out_valid_reg && !out_ready |=> (state_reg == ST_OUT))
        else $error("output stage left while output register was busy");
`endif

endmodule
